// ===== sv/m3it_pkg.sv =====
`default_nettype none
package m3it_pkg;

	// default element format, signed Q16.16
	localparam int DATA_WIDTH_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// matrix elements per beat
	localparam int ELEMS = 9;

	// entries in the queue between cofactor front and divider back
	localparam int QUEUE_DEPTH = 4;

	// result tuser flag positions
	localparam int USER_SINGULAR  = 0;
	localparam int USER_SATURATED = 1;
	localparam int USER_WIDTH     = 2;

endpackage
`default_nettype wire

// ===== sv/matrix3_inverse_transpose.sv =====
// Stages: four cofactor/determinant stages, one queue slot, DATA_WIDTH + 3 divider stages.
// Throughput: one matrix per cycle unless m_axis_tready holds the output; the divider
//   is fully pipelined, one quotient bit per stage for all nine elements at once.
// Reset: arst_n clears all valid bits and the queue; no beat is lost or made after it.
`default_nettype none
module matrix3_inverse_transpose #(
	parameter int DATA_WIDTH    = m3it_pkg::DATA_WIDTH_DEF,
	parameter int FRACTION_BITS = m3it_pkg::FRACTION_BITS_DEF
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        s_axis_tvalid,
	output logic                                       s_axis_tready,
	// in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, zero pad to bytes
	input  wire  [((9*DATA_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire                                        m_axis_tready,
	// out_r0c0 .. out_r2c2, det_value, zero pad to bytes
	output logic [((10*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
	// singular, saturated
	output logic [m3it_pkg::USER_WIDTH-1:0]            m_axis_tuser
);

	localparam int W  = DATA_WIDTH;
	localparam int N  = m3it_pkg::ELEMS;
	localparam int CW = 2 * W + 1;
	localparam int DW = 3 * W + 1;
	localparam int QW = N * CW + DW;

	logic          f_valid, f_ready;
	logic [N*CW-1:0] f_cof;
	logic [DW-1:0] f_det;
	logic [QW-1:0] q_data;
	logic          q_valid, q_ready;
	logic [N*W-1:0] r_elems;
	logic [W-1:0]  r_det;
	logic          r_sing, r_sat;

	// front: cofactors and determinant
	m3it_front #(
		.W(W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_elems (s_axis_tdata[N*W-1:0]),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_cof  (f_cof),
		.out_det  (f_det)
	);

	// queue decoupling front and divider
	m3it_fifo #(
		.WIDTH(QW),
		.DEPTH(m3it_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data ({f_det, f_cof}),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	// back: division, rounding, saturation
	m3it_back #(
		.W(W),
		.F(FRACTION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_valid),
		.in_ready     (q_ready),
		.in_cof       (q_data[N*CW-1:0]),
		.in_det       (q_data[QW-1:N*CW]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_elems    (r_elems),
		.out_det      (r_det),
		.out_singular (r_sing),
		.out_saturated(r_sat)
	);

	// result beat packing
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[N*W-1:0] = r_elems;
		m_axis_tdata[(N+1)*W-1:N*W] = r_det;
		m_axis_tuser = '0;
		m_axis_tuser[m3it_pkg::USER_SINGULAR]  = r_sing;
		m_axis_tuser[m3it_pkg::USER_SATURATED] = r_sat;
	end

	// a singular beat carries zero elements
	a_sing_elems: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[m3it_pkg::USER_SINGULAR]
		|-> m_axis_tdata[N*W-1:0] == '0)
		else $error("singular beat with nonzero elements");

	// a singular beat carries a zero determinant
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[m3it_pkg::USER_SINGULAR]
		|-> m_axis_tdata[(N+1)*W-1:N*W] == '0)
		else $error("singular beat with nonzero determinant");

	// a singular beat is never saturated
	a_sing_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[m3it_pkg::USER_SINGULAR]
		|-> !m_axis_tuser[m3it_pkg::USER_SATURATED])
		else $error("singular beat flagged saturated");

endmodule
`default_nettype wire

// ===== sv/m3it_front.sv =====
`default_nettype none
// Cofactors and determinant, exact, four pipeline stages with a common stall.
module m3it_front #(
	parameter int W = m3it_pkg::DATA_WIDTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  [m3it_pkg::ELEMS*W-1:0]           in_elems,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [m3it_pkg::ELEMS*(2*W+1)-1:0]     out_cof,
	output logic [3*W:0]                           out_det
);

	localparam int N  = m3it_pkg::ELEMS;
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;
	localparam int DW = 3 * W + 1;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [PW-1:0] pa_s1 [N];
	logic signed [PW-1:0] pb_s1 [N];
	logic signed [W-1:0]  row0_s1 [3];
	logic signed [W-1:0]  row0_s2 [3];
	logic [CW-1:0]        cof_s2 [N];
	logic [CW-1:0]        cof_s3 [N];
	logic signed [CW-1:0] lo_s3 [3];
	logic signed [CW-1:0] hi_s3 [3];
	logic [CW-1:0]        cof_s4 [N];
	logic [DW-1:0]        det_s4;
	logic [DW-1:0]        det_sum;

	// whole pipe stalls only when the last stage is held
	assign en        = !vld_s4 || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: the two products of every 2x2 minor
	// stage 2: minor difference with checkerboard sign
	for (genvar i = 0; i < N; i++) begin : g_minor
		localparam int R  = i / 3;
		localparam int C  = i % 3;
		localparam int R1 = (R == 0) ? 1 : 0;
		localparam int R2 = (R == 2) ? 1 : 2;
		localparam int C1 = (C == 0) ? 1 : 0;
		localparam int C2 = (C == 2) ? 1 : 2;
		localparam bit NEG = ((R + C) % 2) == 1;

		logic signed [W-1:0] e11, e22, e12, e21;
		logic [CW-1:0] diff;

		assign e11 = in_elems[(R1*3+C1)*W +: W];
		assign e22 = in_elems[(R2*3+C2)*W +: W];
		assign e12 = in_elems[(R1*3+C2)*W +: W];
		assign e21 = in_elems[(R2*3+C1)*W +: W];

		assign diff = {pa_s1[i][PW-1], pa_s1[i]} - {pb_s1[i][PW-1], pb_s1[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[i]  <= e11 * e22;
				pb_s1[i]  <= e12 * e21;
				cof_s2[i] <= NEG ? (~diff + CW'(1)) : diff;
				cof_s3[i] <= cof_s2[i];
				cof_s4[i] <= cof_s3[i];
			end
		end
	end

	// stage 3: row 0 element times cofactor, cofactor split in two halves
	for (genvar j = 0; j < 3; j++) begin : g_row0
		always_ff @(posedge clk) begin
			if (en) begin
				row0_s1[j] <= in_elems[j*W +: W];
				row0_s2[j] <= row0_s1[j];
				lo_s3[j]   <= row0_s2[j] * $signed({1'b0, cof_s2[j][W-1:0]});
				hi_s3[j]   <= row0_s2[j] * $signed(cof_s2[j][CW-1:W]);
			end
		end
	end

	// stage 4: recombine halves and sum along row 0
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + {hi_s3[j], {W{1'b0}}}
				+ {{W{lo_s3[j][CW-1]}}, lo_s3[j]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= det_sum;
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			out_cof[i*CW +: CW] = cof_s4[i];
		end
	end
	assign out_det = det_s4;

endmodule
`default_nettype wire

// ===== sv/m3it_fifo.sv =====
`default_nettype none
// Small register queue, first in first out.
module m3it_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = m3it_pkg::QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire  [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNTW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/m3it_back.sv =====
`default_nettype none
// Nine restoring dividers in lockstep, one quotient bit per stage,
// then rounding, clamping and the singular override.
module m3it_back #(
	parameter int W = m3it_pkg::DATA_WIDTH_DEF,
	parameter int F = m3it_pkg::FRACTION_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [m3it_pkg::ELEMS*(2*W+1)-1:0] in_cof,
	input  wire  [3*W:0]                       in_det,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [m3it_pkg::ELEMS*W-1:0]       out_elems,
	output logic [W-1:0]                       out_det,
	output logic                               out_singular,
	output logic                               out_saturated
);

	localparam int N  = m3it_pkg::ELEMS;
	localparam int CW = 2 * W + 1;
	localparam int DW = 3 * W + 1;
	localparam int QB = W + 1;
	localparam int NW = CW + 2 * F;
	localparam int RW = (NW > DW + QB) ? NW : DW + QB;

	logic en;
	logic [QB+1:0] vld_s;

	// stage 0 is preparation, stages 1..QB each settle one quotient bit
	logic [RW-1:0]  rem_s [0:QB][N];
	logic [QB-1:0]  quo_s [0:QB][N];
	logic [DW-1:0]  den_s [0:QB];
	logic [N-1:0]   neg_s [0:QB];
	logic [N-1:0]   ovf_s [0:QB];
	logic           sing_s [0:QB];
	logic [W-1:0]   detv_s [0:QB];
	logic           dsat_s [0:QB];

	logic [N*W-1:0] elems_q;
	logic [W-1:0]   det_q;
	logic           sing_q, sat_q;

	assign en        = !vld_s[QB+1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB:0], in_valid};
		end
	end

	// preparation: magnitudes, overflow test, determinant output
	logic           det_neg;
	logic [DW-1:0]  den;
	logic [RW-1:0]  den_top;
	logic [RW-1:0]  num [N];
	logic [N-1:0]   cneg, ovf;
	logic [CW-1:0]  cmag [N];
	logic [DW:0]    drnd, dsh;
	logic [W-1:0]   dlim, dmag, detv;
	logic           dsat;

	always_comb begin
		det_neg = in_det[DW-1];
		den     = det_neg ? (~in_det + DW'(1)) : in_det;
		den_top = '0;
		den_top[DW+QB-1:QB] = den;
		for (int i = 0; i < N; i++) begin
			cneg[i] = in_cof[i*CW + CW - 1];
			cmag[i] = cneg[i] ? (~in_cof[i*CW +: CW] + CW'(1)) : in_cof[i*CW +: CW];
			num[i]  = '0;
			num[i][NW-1:0] = {cmag[i], {(2*F){1'b0}}};
			ovf[i]  = num[i] >= den_top;
		end
		// determinant scaled down by 2F fraction bits, rounded half away from zero
		drnd = {1'b0, den} + ((DW+1)'(1) << (2*F - 1));
		dsh  = drnd >> (2*F);
		dlim = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, det_neg};
		dsat = (dsh[DW:W] != '0) || (dsh[W-1:0] > dlim);
		dmag = dsat ? dlim : dsh[W-1:0];
		detv = det_neg ? (~dmag + W'(1)) : dmag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rem_s[0][i] <= num[i];
				quo_s[0][i] <= '0;
			end
			den_s[0]  <= den;
			neg_s[0]  <= cneg ^ {N{det_neg}};
			ovf_s[0]  <= ovf;
			sing_s[0] <= den == '0;
			detv_s[0] <= detv;
			dsat_s[0] <= dsat;
		end
	end

	// one restoring step per stage, divisor aligned to quotient bit QB-k
	for (genvar k = 1; k <= QB; k++) begin : g_step
		localparam int SH = QB - k;

		logic [RW-1:0] dsub;

		always_comb begin
			dsub = '0;
			dsub[DW+SH-1:SH] = den_s[k-1];
		end

		for (genvar i = 0; i < N; i++) begin : g_lane
			logic take;

			assign take = rem_s[k-1][i] >= dsub;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][i] <= take ? rem_s[k-1][i] - dsub : rem_s[k-1][i];
					quo_s[k][i] <= {quo_s[k-1][i][QB-2:0], take};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				sing_s[k] <= sing_s[k-1];
				detv_s[k] <= detv_s[k-1];
				dsat_s[k] <= dsat_s[k-1];
			end
		end
	end

	// round half away from zero, clamp, apply sign, zero on singular
	logic [RW:0]    rem2 [N];
	logic [RW:0]    den_ext;
	logic [QB:0]    qr [N];
	logic [W-1:0]   elim [N];
	logic [W-1:0]   emag [N];
	logic [N-1:0]   esat;
	logic [N*W-1:0] elems;

	always_comb begin
		den_ext = '0;
		den_ext[DW-1:0] = den_s[QB];
		for (int i = 0; i < N; i++) begin
			rem2[i] = {rem_s[QB][i], 1'b0};
			qr[i]   = {1'b0, quo_s[QB][i]} + {{QB{1'b0}}, rem2[i] >= den_ext};
			elim[i] = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg_s[QB][i]};
			esat[i] = ovf_s[QB][i] || (qr[i][QB:W] != '0) || (qr[i][W-1:0] > elim[i]);
			emag[i] = esat[i] ? elim[i] : qr[i][W-1:0];
			elems[i*W +: W] = sing_s[QB] ? '0
				: (neg_s[QB][i] ? (~emag[i] + W'(1)) : emag[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elems_q <= elems;
			det_q   <= sing_s[QB] ? '0 : detv_s[QB];
			sing_q  <= sing_s[QB];
			sat_q   <= dsat_s[QB] || (!sing_s[QB] && (esat != '0));
		end
	end

	assign out_elems     = elems_q;
	assign out_det       = det_q;
	assign out_singular  = sing_q;
	assign out_saturated = sat_q;

endmodule
`default_nettype wire
